[rtl/bba_pkg.sv]
// Package for the bitmap block allocator: command and status codes,
// port field widths and the reserved-block constant.
// No dependencies; imported by the allocator top level.
package bba_pkg;

    // Field widths of the stream words and the configuration register.
    localparam int FUNC_W    = 2;
    localparam int BLK_W     = 15;
    localparam int ST_W      = 2;
    localparam int CNT_W     = 15;
    localparam int CFG_W     = 16;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    // Command codes carried in the input tuser field.
    localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FORMAT = 2'd2;

    // Status codes carried in the output tuser field.
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    // Block 0 is kept used as the null block.
    localparam logic [7:0] RESERVED_MASK = 8'h01;

    // Block total after reset.
    localparam logic [CFG_W-1:0] TOTAL_RESET = 16'h8000;

endpackage

[rtl/bba_scan_unit.sv]
// Word scanner of the bitmap block allocator: finds the lowest free block
// inside one map word that lies below the block total.
// No package dependency; instanced by the allocator top level.
module bba_scan_unit #(
    parameter int WORD_BITS = 32,
    parameter int TOT_W     = 18
) (
    input  logic [WORD_BITS-1:0]         map_word,
    input  logic [TOT_W-1:0]             base,
    input  logic [TOT_W-1:0]             total,
    output logic                         found,
    output logic [$clog2(WORD_BITS)-1:0] bit_idx,
    output logic                         more
);
    localparam int SW = $clog2(WORD_BITS);

    logic [TOT_W-1:0]     lim;
    logic [WORD_BITS-1:0] free_bits;

    // Number of blocks of this word that lie below the total.
    assign lim  = total - base;
    assign more = (base + TOT_W'(WORD_BITS)) < total;

    // A bit is a candidate when clear, in range and not the null block.
    always_comb begin
        for (int k = 0; k < WORD_BITS; k++) begin
            free_bits[k] = !map_word[k] && (TOT_W'(k) < lim) &&
                           !((base == '0) && (k == 0));
        end
    end

    // Lowest candidate wins.
    always_comb begin
        found   = 1'b0;
        bit_idx = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (free_bits[k]) begin
                found   = 1'b1;
                bit_idx = SW'(k);
            end
        end
    end

endmodule

[rtl/bitmap_block_allocator.sv]
// Usage:
// Input words arrive on s_axis: tuser carries the command (allocate, free,
// format) and tdata the block number for free. Each command gives exactly one
// output word on m_axis: tdata holds the allocated block number and the free
// count, tuser the status. The block total is written through cfg_wr_en and
// cfg_wr_data, clamped to 1..MAX_BLOCKS; the user must write it only while the
// block is idle, as the block itself does not enforce it. The usage map is a
// RAM of MAX_BLOCKS / MAP_WORD_BITS words, one write port and one registered
// read port; the scan unit inspects one word a cycle. Allocate scans the map
// words from word 0 up (at most total / MAP_WORD_BITS rounded up, 1024 at the
// defaults) and stops at the first free block. Free clears the block's bit in
// S_FREE_WR; a free out of range, or an unused command, goes to S_DONE. Format
// walks the whole map, one word per cycle. One command is handled at a time;
// s_axis_tready is high only between commands, from the cycle after the output
// register loads. That register holds a finished word while m_axis_tready is
// low, and the next command is already accepted meanwhile; its own result then
// waits until the register is taken.
// After reset the same clearing pass runs with s_axis_tready low; configuration
// writes are taken during it.
// MAP_WORD_BITS must be a power of two.
module bitmap_block_allocator #(
    parameter int MAX_BLOCKS    = 32768,
    parameter int MAP_WORD_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration: block total.
    input  logic                           cfg_wr_en,
    input  logic [bba_pkg::CFG_W-1:0]      cfg_wr_data,
    // Command stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bba_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // block[14:0], zero[15]
    input  logic [bba_pkg::FUNC_W-1:0]     s_axis_tuser,  // func[1:0]
    // Result stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [bba_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // block_number[14:0],
                                                          // free_count[29:15], zero[31:30]
    output logic [bba_pkg::ST_W-1:0]       m_axis_tuser   // status[1:0]
);
    import bba_pkg::*;

    localparam int WB      = MAP_WORD_BITS;
    localparam int SW      = $clog2(WB);
    localparam int DEPTH   = (MAX_BLOCKS + WB - 1) / WB;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TOT_W   = ($clog2(MAX_BLOCKS + 1) + 2 > 18) ?
                             $clog2(MAX_BLOCKS + 1) + 2 : 18;
    localparam int RESET_EFF = (32768 < MAX_BLOCKS) ? 32768 : MAX_BLOCKS;
    localparam logic [TOT_W-1:0] RESET_FREE = TOT_W'(RESET_EFF - 1);
    localparam logic [AW-1:0]    LAST_WORD  = AW'(DEPTH - 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHK     = 3'd1;
    localparam logic [2:0] S_FREE_WR = 3'd2;
    localparam logic [2:0] S_CLR     = 3'd3;
    localparam logic [2:0] S_DONE    = 3'd4;

    logic [2:0]        state_reg,   state_next;
    logic [CFG_W-1:0]  total_reg;
    logic [TOT_W-1:0]  free_total_reg, free_total_next;
    logic [AW-1:0]     word_reg,    word_next;
    logic [TOT_W-1:0]  base_reg,    base_next;
    logic [AW-1:0]     clr_reg,     clr_next;
    logic              fmt_reg,     fmt_next;
    logic [BLK_W-1:0]  blk_reg,     blk_next;
    logic [BLK_W-1:0]  res_blk_reg, res_blk_next;
    logic [ST_W-1:0]   res_st_reg,  res_st_next;
    logic              m_valid_reg, m_valid_next;
    logic [BLK_W-1:0]  m_blk_reg;
    logic [ST_W-1:0]   m_st_reg;
    logic [CNT_W-1:0]  m_cnt_reg;

    logic [WB-1:0]     map_mem [DEPTH];
    logic [WB-1:0]     map_rdata_reg;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [WB-1:0]     mem_wd;

    logic [TOT_W-1:0]  eff_total;
    logic [TOT_W-1:0]  total_m1;
    logic [TOT_W-1:0]  tb_ext;
    logic [BLK_W-1:0]  s_blk;
    logic [TOT_W-1:0]  s_blk_ext;
    logic [AW-1:0]     s_word;
    logic [TOT_W-1:0]  blk_ext;
    logic              scan_found;
    logic [SW-1:0]     scan_idx;
    logic              scan_more;
    logic              load;

    // Effective total: zero acts as one, large values clamp to MAX_BLOCKS.
    assign tb_ext = TOT_W'(total_reg);
    always_comb begin
        if (total_reg == '0) begin
            eff_total = TOT_W'(1);
        end else if (tb_ext > TOT_W'(MAX_BLOCKS)) begin
            eff_total = TOT_W'(MAX_BLOCKS);
        end else begin
            eff_total = tb_ext;
        end
    end
    assign total_m1 = eff_total - TOT_W'(1);

    // Input fields and the map word that holds the block to free.
    assign s_blk     = s_axis_tdata[BLK_W-1:0];
    assign s_blk_ext = TOT_W'(s_blk);
    assign s_word    = s_blk_ext[SW +: AW];
    assign blk_ext   = TOT_W'(blk_reg);

    // Word scanner for the allocate search.
    bba_scan_unit #(
        .WORD_BITS (WB),
        .TOT_W     (TOT_W)
    ) u_scan (
        .map_word (map_rdata_reg),
        .base     (base_reg),
        .total    (eff_total),
        .found    (scan_found),
        .bit_idx  (scan_idx),
        .more     (scan_more)
    );

    // Usage map RAM: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_wa] <= mem_wd;
        end
        map_rdata_reg <= map_mem[rd_addr];
    end

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        free_total_next = free_total_reg;
        word_next       = word_reg;
        base_next       = base_reg;
        clr_next        = clr_reg;
        fmt_next        = fmt_reg;
        blk_next        = blk_reg;
        res_blk_next    = res_blk_reg;
        res_st_next     = res_st_reg;
        rd_addr         = '0;
        mem_we          = 1'b0;
        mem_wa          = word_reg;
        mem_wd          = map_rdata_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    blk_next     = s_blk;
                    res_blk_next = '0;
                    res_st_next  = ST_OK;
                    unique case (s_axis_tuser)
                        FUNC_ALLOC: begin
                            word_next  = '0;
                            base_next  = '0;
                            rd_addr    = '0;
                            state_next = S_CHK;
                        end
                        FUNC_FREE: begin
                            word_next = s_word;
                            rd_addr   = s_word;
                            if ((s_blk == '0) || (s_blk_ext >= eff_total)) begin
                                res_st_next = ST_RANGE;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_FREE_WR;
                            end
                        end
                        FUNC_FORMAT: begin
                            free_total_next = total_m1;
                            clr_next        = '0;
                            fmt_next        = 1'b1;
                            state_next      = S_CLR;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CHK: begin
                // One map word per cycle; the next read is launched meanwhile.
                if (scan_found) begin
                    mem_we       = 1'b1;
                    mem_wd       = map_rdata_reg | (WB'(1) << scan_idx);
                    res_blk_next = BLK_W'(base_reg + TOT_W'(scan_idx));
                    if (free_total_reg != '0) begin
                        free_total_next = free_total_reg - TOT_W'(1);
                    end
                    state_next = S_DONE;
                end else if (scan_more) begin
                    word_next = word_reg + AW'(1);
                    base_next = base_reg + TOT_W'(WB);
                    rd_addr   = word_reg + AW'(1);
                end else begin
                    res_st_next = ST_FULL;
                    state_next  = S_DONE;
                end
            end
            S_FREE_WR: begin
                mem_we = 1'b1;
                mem_wd = map_rdata_reg & ~(WB'(1) << blk_ext[SW-1:0]);
                if (free_total_reg < total_m1) begin
                    free_total_next = free_total_reg + TOT_W'(1);
                end else begin
                    free_total_next = total_m1;
                end
                state_next = S_DONE;
            end
            S_CLR: begin
                // Clearing pass; word 0 keeps the null block reserved.
                mem_we = 1'b1;
                mem_wa = clr_reg;
                mem_wd = (clr_reg == '0) ? WB'(RESERVED_MASK) : '0;
                if (clr_reg == LAST_WORD) begin
                    fmt_next   = 1'b0;
                    state_next = fmt_reg ? S_DONE : S_IDLE;
                end else begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register loads when the finished word finds a free slot.
    assign load         = (state_reg == S_DONE) && (!m_valid_reg || m_axis_tready);
    assign m_valid_next = load || (m_valid_reg && !m_axis_tready);

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLR;
            total_reg      <= TOTAL_RESET;
            free_total_reg <= RESET_FREE;
            clr_reg        <= '0;
            fmt_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            free_total_reg <= free_total_next;
            clr_reg        <= clr_next;
            fmt_reg        <= fmt_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                total_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        word_reg    <= word_next;
        base_reg    <= base_next;
        blk_reg     <= blk_next;
        res_blk_reg <= res_blk_next;
        res_st_reg  <= res_st_next;
        if (load) begin
            m_blk_reg <= res_blk_reg;
            m_st_reg  <= res_st_reg;
            m_cnt_reg <= free_total_reg[CNT_W-1:0];
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - BLK_W - CNT_W){1'b0}}, m_cnt_reg, m_blk_reg};
    assign m_axis_tuser  = m_st_reg;

`ifndef SYNTH
    // No command is taken while the map is being cleared.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLR) |-> !s_axis_tready)
        else $error("command accepted during clearing pass");

    // A full map never reports a block number.
    a_full_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser == ST_FULL)) |-> (m_axis_tdata[BLK_W-1:0] == '0))
        else $error("full status with a nonzero block number");

    // A new output word comes only from the done state.
    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("output word loaded outside the done state");

    // The scan never looks at a word that starts at or above the total.
    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHK) |-> (base_reg < eff_total))
        else $error("scan beyond the block total");
`endif

endmodule
